/* src/jst_pkg.sv */
// ----------------------------------------------------------------------------
// jst_pkg
// shared constants, types and byte class helpers of the json stream tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package jst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int POS_BITS    = 24;
  localparam int LIMIT_W     = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

  localparam logic [1:0] TYPE_OBJECT    = 2'd0;
  localparam logic [1:0] TYPE_ARRAY     = 2'd1;
  localparam logic [1:0] TYPE_STRING    = 2'd2;
  localparam logic [1:0] TYPE_PRIMITIVE = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_MALFORMED = 2'd1;
  localparam logic [1:0] ERR_FULL      = 2'd2;

  localparam logic KIND_TOKEN  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;

  typedef enum logic [4:0] {
    MODE_BETWEEN   = 5'b00001,
    MODE_STRING    = 5'b00010,
    MODE_ESCAPE    = 5'b00100,
    MODE_HEX       = 5'b01000,
    MODE_PRIMITIVE = 5'b10000
  } mode_e;

  // one table entry, container entries only ever get read back
  typedef struct packed {
    logic [1:0]          ttype;
    logic signed [8:0]   parent;
    logic [POS_BITS-1:0] start;
    logic [7:0]          kids;
  } entry_t;

  typedef struct packed {
    logic                record_kind;
    logic [7:0]          token_index;
    logic [1:0]          token_type;
    logic [23:0]         token_start;
    logic [24:0]         token_end;
    logic [7:0]          child_count;
    logic signed [8:0]   parent_index;
    logic [1:0]          parse_status;
    logic [8:0]          token_total;
    logic                run_last;
  } rec_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic logic is_esc(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_BSLASH) || (c == 8'h2f) || (c == 8'h62) ||
           (c == 8'h66) || (c == 8'h6e) || (c == 8'h72) || (c == 8'h74);
  endfunction

endpackage

`default_nettype wire

/* src/jst_byte_if.sv */
// ----------------------------------------------------------------------------
// jst_byte_if
// input channel: one byte of text per word, with a final byte flag
// ----------------------------------------------------------------------------
`default_nettype none

interface jst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

/* src/jst_rec_if.sv */
// ----------------------------------------------------------------------------
// jst_rec_if
// output channel: one token record or final status per word
// ----------------------------------------------------------------------------
`default_nettype none

interface jst_rec_if;
  logic              valid;
  logic              ready;
  logic              record_kind;
  logic [7:0]        token_index;
  logic [1:0]        token_type;
  logic [23:0]       token_start;
  logic [24:0]       token_end;
  logic [7:0]        child_count;
  logic signed [8:0] parent_index;
  logic [1:0]        parse_status;
  logic [8:0]        token_total;
  logic              run_last;

  modport source (output valid, record_kind, token_index, token_type, token_start,
                  token_end, child_count, parent_index, parse_status, token_total,
                  run_last, input ready);
  modport sink   (input valid, record_kind, token_index, token_type, token_start,
                  token_end, child_count, parent_index, parse_status, token_total,
                  run_last, output ready);
endinterface

`default_nettype wire

/* src/jst_table.sv */
// ----------------------------------------------------------------------------
// jst_table
// token table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module jst_table
  import jst_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_addr_i,
  input  wire entry_t           wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [IDX_W-1:0] rd_addr_i,
  output entry_t                rd_data_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

/* src/jst_outq.sv */
// ----------------------------------------------------------------------------
// jst_outq
// result queue, takes up to three records per cycle and hands out one
// ----------------------------------------------------------------------------
`default_nettype none

module jst_outq
  import jst_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic [1:0] push_n_i,
  input  wire rec_t  push_rec_i [3],
  output logic       room_o,
  jst_rec_if.source  out_o
);

  rec_t       buf_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;
  rec_t       head;

  assign pop    = out_o.valid && out_o.ready;
  assign room_o = (count_q <= 3'd1);
  assign head   = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n_i) begin
        buf_q[wr_ptr_q + 2'(i)] <= push_rec_i[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n_i;
      rd_ptr_q <= rd_ptr_q + 2'(pop);
      count_q  <= count_q + 3'(push_n_i) - 3'(pop);
    end
  end

  assign out_o.valid        = (count_q != 3'd0);
  assign out_o.record_kind  = head.record_kind;
  assign out_o.token_index  = head.token_index;
  assign out_o.token_type   = head.token_type;
  assign out_o.token_start  = head.token_start;
  assign out_o.token_end    = head.token_end;
  assign out_o.child_count  = head.child_count;
  assign out_o.parent_index = head.parent_index;
  assign out_o.parse_status = head.parse_status;
  assign out_o.token_total  = head.token_total;
  assign out_o.run_last     = head.run_last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> (count_q <= 3'd1))
    else $error("result queue written without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("result queue count out of range");

endmodule

`default_nettype wire

/* src/json_stream_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// json_stream_tokenizer_core
// byte serial json tokenizer keeping container entries in a token table
// ----------------------------------------------------------------------------
// channel   dir  word                                     accepted when
// in_i      in   data_byte, last_byte                     valid && ready
// out_o     out  token record or final status             valid && ready
// cfg       in   token_limit (9 bits)                     cfg_we_i high
//
// a byte is taken and fully lexed in the cycle it is accepted, one per cycle
// a closing bracket with an enclosing container also reloads the cache: the
// parent entry is read from the table memory (registered read) into the
// open container cache, and input is held off meanwhile
// results go through a four word queue, input waits while it holds two or more
// reset is asynchronous, the table memory itself is never cleared
// ----------------------------------------------------------------------------
`default_nettype none

module json_stream_tokenizer_core
  import jst_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [LIMIT_W-1:0] cfg_wdata_i,
  jst_byte_if.sink                in_i,
  jst_rec_if.source               out_o
);

  // parse state
  logic [CNT_W-1:0]    next_free_q, next_free_d;
  logic signed [8:0]   oc_q, oc_d;           // innermost open container, -1 none
  logic [1:0]          tlc_q, tlc_d;         // top level values, saturating
  logic [POS_BITS:0]   pos_q, pos_d;
  mode_e               mode_q, mode_d;
  logic [2:0]          hex_q, hex_d;
  logic [POS_BITS-1:0] pend_q, pend_d;
  logic [1:0]          err_q, err_d;
  logic [LIMIT_W-1:0]  limit_q;
  logic                refill_q, refill_d;

  // cached entry of the open container, written back when a child opens
  entry_t              oc_ent_q, oc_ent_d;

  // table port
  logic                wr_en, rd_en;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  entry_t              wr_data, rd_data;

  // result slots
  rec_t                recs [3];
  logic [1:0]          rec_n;
  logic                room;
  logic                acc;

  assign in_i.ready = room && !refill_q;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    logic [7:0]          c;
    logic [POS_BITS-1:0] pos;
    logic [CNT_W-1:0]    lim;
    logic                leaf, do_between, is_close, is_open;
    logic [1:0]          ltype, want;
    rec_t                r;

    c          = in_i.data_byte;
    pos        = pos_q[POS_BITS-1:0];
    lim        = (limit_q > LIMIT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(limit_q);
    leaf       = 1'b0;
    do_between = 1'b0;
    is_close   = 1'b0;
    is_open    = 1'b0;
    ltype      = TYPE_PRIMITIVE;
    want       = TYPE_OBJECT;
    r          = '0;

    next_free_d = next_free_q;
    oc_d        = oc_q;
    tlc_d       = tlc_q;
    pos_d       = pos_q;
    mode_d      = mode_q;
    hex_d       = hex_q;
    pend_d      = pend_q;
    err_d       = err_q;
    refill_d    = 1'b0;
    oc_ent_d    = refill_q ? rd_data : oc_ent_q;

    wr_en   = 1'b0;
    wr_addr = oc_q[IDX_W-1:0];
    wr_data = oc_ent_q;
    rd_en   = 1'b0;
    rd_addr = oc_ent_q.parent[IDX_W-1:0];

    recs[0] = '0;
    recs[1] = '0;
    recs[2] = '0;
    rec_n   = 2'd0;

    if (acc) begin
      if (err_q == ERR_NONE) begin
        if (pos_q[POS_BITS]) begin
          // text longer than the position field
          err_d = ERR_MALFORMED;
        end else begin
          pos_d = pos_q + 1'b1;
          case (mode_q)
            MODE_PRIMITIVE: begin
              if (is_space(c) || c == 8'h2c || c == 8'h5d || c == 8'h7d || c == 8'h3a) begin
                leaf       = 1'b1;
                ltype      = TYPE_PRIMITIVE;
                mode_d     = MODE_BETWEEN;
                do_between = 1'b1;
              end else if (c < CTRL_LIMIT || c == CH_QUOTE || c == 8'h7b || c == 8'h5b) begin
                err_d = ERR_MALFORMED;
              end
            end
            MODE_STRING: begin
              if (c == CH_QUOTE) begin
                leaf   = 1'b1;
                ltype  = TYPE_STRING;
                mode_d = MODE_BETWEEN;
              end else if (c < CTRL_LIMIT) begin
                err_d = ERR_MALFORMED;
              end else if (c == CH_BSLASH) begin
                mode_d = MODE_ESCAPE;
              end
            end
            MODE_ESCAPE: begin
              if (c == CH_U) begin
                mode_d = MODE_HEX;
                hex_d  = 3'd4;
              end else if (is_esc(c)) begin
                mode_d = MODE_STRING;
              end else begin
                err_d = ERR_MALFORMED;
              end
            end
            MODE_HEX: begin
              if (!is_hex(c)) begin
                err_d = ERR_MALFORMED;
              end else begin
                hex_d = (hex_q != 3'd0) ? hex_q - 3'd1 : 3'd0;
                if (hex_d == 3'd0) begin
                  mode_d = MODE_STRING;
                end
              end
            end
            default: begin
              do_between = 1'b1;
            end
          endcase

          // leaf allocation, string or primitive that just ended
          if (leaf) begin
            if (next_free_d >= lim) begin
              err_d = ERR_FULL;
            end else begin
              r              = '0;
              r.record_kind  = KIND_TOKEN;
              r.token_index  = next_free_d[IDX_W-1:0];
              r.token_type   = ltype;
              r.token_start  = pend_q;
              r.token_end    = 25'(pos);
              r.parent_index = oc_d;
              recs[rec_n]    = r;
              rec_n          = rec_n + 2'd1;
              if (!oc_d[8]) begin
                if (oc_ent_d.kids != 8'hff) oc_ent_d.kids = oc_ent_d.kids + 8'd1;
              end else if (tlc_d != 2'd2) begin
                tlc_d = tlc_d + 2'd1;
              end
              next_free_d = next_free_d + 1'b1;
            end
          end

          if (do_between && err_d == ERR_NONE) begin
            if (is_space(c) || c == 8'h3a || c == 8'h2c) begin
              // skipped
            end else if (c == 8'h7b || c == 8'h5b) begin
              is_open = 1'b1;
            end else if (c == 8'h7d || c == 8'h5d) begin
              is_close = 1'b1;
            end else if (c == CH_QUOTE) begin
              mode_d = MODE_STRING;
              pend_d = pos + 1'b1;
            end else if (c < CTRL_LIMIT) begin
              err_d = ERR_MALFORMED;
            end else begin
              mode_d = MODE_PRIMITIVE;
              pend_d = pos;
            end
          end

          if (is_open) begin
            if (next_free_d >= lim) begin
              err_d = ERR_FULL;
            end else begin
              if (!oc_d[8]) begin
                if (oc_ent_d.kids != 8'hff) oc_ent_d.kids = oc_ent_d.kids + 8'd1;
                // park the enclosing container in the table
                wr_en   = 1'b1;
                wr_addr = oc_d[IDX_W-1:0];
                wr_data = oc_ent_d;
              end else if (tlc_d != 2'd2) begin
                tlc_d = tlc_d + 2'd1;
              end
              oc_ent_d.ttype  = (c == 8'h7b) ? TYPE_OBJECT : TYPE_ARRAY;
              oc_ent_d.parent = oc_d;
              oc_ent_d.start  = pos;
              oc_ent_d.kids   = 8'd0;
              oc_d            = $signed({1'b0, next_free_d[IDX_W-1:0]});
              next_free_d     = next_free_d + 1'b1;
            end
          end

          if (is_close) begin
            want = (c == 8'h7d) ? TYPE_OBJECT : TYPE_ARRAY;
            if (oc_d[8] || oc_ent_d.ttype != want) begin
              err_d = ERR_MALFORMED;
            end else begin
              r              = '0;
              r.record_kind  = KIND_TOKEN;
              r.token_index  = oc_d[IDX_W-1:0];
              r.token_type   = want;
              r.token_start  = oc_ent_d.start;
              r.token_end    = 25'(pos) + 25'd1;
              r.child_count  = oc_ent_d.kids;
              r.parent_index = oc_ent_d.parent;
              recs[rec_n]    = r;
              rec_n          = rec_n + 2'd1;
              oc_d           = oc_ent_d.parent;
              // fetch the enclosing container back into the cache
              if (!oc_ent_d.parent[8]) begin
                rd_en    = 1'b1;
                rd_addr  = oc_ent_d.parent[IDX_W-1:0];
                refill_d = 1'b1;
              end
            end
          end
        end
      end

      if (in_i.last_byte) begin
        if (err_d == ERR_NONE) begin
          if (mode_d == MODE_PRIMITIVE) begin
            // primitive running to the end of the text
            if (next_free_d >= lim) begin
              err_d = ERR_FULL;
            end else begin
              r              = '0;
              r.record_kind  = KIND_TOKEN;
              r.token_index  = next_free_d[IDX_W-1:0];
              r.token_type   = TYPE_PRIMITIVE;
              r.token_start  = pend_d;
              r.token_end    = pos_d;
              r.parent_index = oc_d;
              recs[rec_n]    = r;
              rec_n          = rec_n + 2'd1;
              if (oc_d[8] && tlc_d != 2'd2) tlc_d = tlc_d + 2'd1;
              next_free_d = next_free_d + 1'b1;
            end
          end else if (mode_d != MODE_BETWEEN) begin
            err_d = ERR_MALFORMED;
          end
        end
        if (err_d == ERR_NONE && (!oc_d[8] || tlc_d != 2'd1)) begin
          err_d = ERR_MALFORMED;
        end
        r              = '0;
        r.record_kind  = KIND_STATUS;
        r.parse_status = err_d;
        r.token_total  = next_free_d;
        recs[rec_n]    = r;
        rec_n          = rec_n + 2'd1;

        next_free_d = '0;
        oc_d        = -9'sd1;
        tlc_d       = 2'd0;
        pos_d       = '0;
        mode_d      = MODE_BETWEEN;
        hex_d       = 3'd0;
        pend_d      = '0;
        err_d       = ERR_NONE;
        refill_d    = 1'b0;
      end

      if (rec_n != 2'd0) begin
        recs[rec_n - 2'd1].run_last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_free_q <= '0;
      oc_q        <= -9'sd1;
      tlc_q       <= 2'd0;
      pos_q       <= '0;
      mode_q      <= MODE_BETWEEN;
      hex_q       <= 3'd0;
      pend_q      <= '0;
      err_q       <= ERR_NONE;
      limit_q     <= LIMIT_RESET;
      refill_q    <= 1'b0;
    end else begin
      next_free_q <= next_free_d;
      oc_q        <= oc_d;
      tlc_q       <= tlc_d;
      pos_q       <= pos_d;
      mode_q      <= mode_d;
      hex_q       <= hex_d;
      pend_q      <= pend_d;
      err_q       <= err_d;
      refill_q    <= refill_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  // cache payload, loaded on open or on refill and updated as children are counted
  always_ff @(posedge clk_i) begin
    oc_ent_q <= oc_ent_d;
  end

  jst_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  jst_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_n_i   (rec_n),
    .push_rec_i (recs),
    .room_o     (room),
    .out_o      (out_o)
  );

  a_refill_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refill_q |-> !in_i.ready)
    else $error("byte taken while container cache reloads");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_i.last_byte) |=> (next_free_q == '0 && oc_q == -9'sd1 && err_q == ERR_NONE))
    else $error("parse state not cleared after final byte");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= CNT_W'(TABLE_DEPTH))
    else $error("allocation index beyond table");

  a_refill_has_parent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    refill_q |-> !oc_q[8])
    else $error("cache reload with no open container");

endmodule

`default_nettype wire

/* verif/jst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_checker
// watches the byte and record channels and the limit register port, models
// the tokenizer byte by byte and checks every record word against the model
// ----------------------------------------------------------------------------

module jst_checker
  import jst_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  jst_byte_if                in_i,
  jst_rec_if                 out_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 statuses_o
);

  localparam int M_BETWEEN = 0, M_STRING = 1, M_ESCAPE = 2, M_HEX = 3, M_PRIM = 4;

  logic [1:0]  tbl_type  [TABLE_DEPTH];
  int          tbl_parent[TABLE_DEPTH];
  logic [23:0] tbl_start [TABLE_DEPTH];
  int          tbl_kids  [TABLE_DEPTH];

  int          alloc_ptr, cur_open, top_vals, lex_mode, hex_cnt;
  logic [24:0] pos_q, pend_start;
  logic [1:0]  err_q;
  int          limit_q;
  rec_t        want_q[$];

  function automatic rec_t mk(logic kind, int idx, logic [1:0] ty, logic [24:0] st,
                              logic [24:0] en, int kids, int par, logic [1:0] stat,
                              int total);
    rec_t r;
    r.record_kind  = kind;
    r.token_index  = idx[7:0];
    r.token_type   = ty;
    r.token_start  = st[23:0];
    r.token_end    = en;
    r.child_count  = kids[7:0];
    r.parent_index = par[8:0];
    r.parse_status = stat;
    r.token_total  = total[8:0];
    r.run_last     = 1'b0;
    return r;
  endfunction

  function automatic void clear_text();
    alloc_ptr  = 0;
    cur_open   = -1;
    top_vals   = 0;
    pos_q      = '0;
    lex_mode   = M_BETWEEN;
    hex_cnt    = 0;
    pend_start = '0;
    err_q      = ERR_NONE;
  endfunction

  function automatic int take_entry(logic [1:0] ty, logic [24:0] st);
    int lim;
    int idx;
    lim = (limit_q > TABLE_DEPTH) ? TABLE_DEPTH : limit_q;
    if (alloc_ptr >= lim) begin
      err_q = ERR_FULL;
      return -1;
    end
    idx = alloc_ptr;
    tbl_type[idx]   = ty;
    tbl_parent[idx] = cur_open;
    tbl_start[idx]  = st[23:0];
    tbl_kids[idx]   = 0;
    if (cur_open >= 0) begin
      if (tbl_kids[cur_open] < 255) tbl_kids[cur_open]++;
    end else if (top_vals < 2) begin
      top_vals++;
    end
    alloc_ptr++;
    return idx;
  endfunction

  function automatic void leaf_done(logic [1:0] ty, logic [24:0] st, logic [24:0] en);
    int par;
    int idx;
    par = cur_open;
    idx = take_entry(ty, st);
    if (idx >= 0) want_q.push_back(mk(KIND_TOKEN, idx, ty, st, en, 0, par, ERR_NONE, 0));
  endfunction

  function automatic logic ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0a;
  endfunction

  function automatic void between_tokens(logic [7:0] c, logic [24:0] p);
    logic [1:0] kind_want;
    int idx;
    if (ws(c) || c == ":" || c == ",") return;
    if (c == "{" || c == "[") begin
      idx = take_entry(c == "{" ? TYPE_OBJECT : TYPE_ARRAY, p);
      if (idx >= 0) cur_open = idx;
    end else if (c == "}" || c == "]") begin
      kind_want = (c == "}") ? TYPE_OBJECT : TYPE_ARRAY;
      if (cur_open < 0 || tbl_type[cur_open] != kind_want) begin
        err_q = ERR_MALFORMED;
        return;
      end
      want_q.push_back(mk(KIND_TOKEN, cur_open, kind_want, {1'b0, tbl_start[cur_open]},
                          p + 25'd1, tbl_kids[cur_open], tbl_parent[cur_open],
                          ERR_NONE, 0));
      cur_open = tbl_parent[cur_open];
    end else if (c == CH_QUOTE) begin
      lex_mode   = M_STRING;
      pend_start = p + 25'd1;
    end else if (c < CTRL_LIMIT) begin
      err_q = ERR_MALFORMED;
    end else begin
      lex_mode   = M_PRIM;
      pend_start = p;
    end
  endfunction

  // one accepted byte, expected words go to want_q
  function automatic void lex_byte(logic [7:0] c, logic fin);
    int n_prev;
    logic [24:0] p;
    n_prev = want_q.size();
    if (err_q == ERR_NONE) begin
      if (pos_q >= 25'(1 << 24)) begin
        err_q = ERR_MALFORMED;
      end else begin
        p = pos_q;
        pos_q++;
        case (lex_mode)
          M_PRIM: begin
            if (ws(c) || c == "," || c == "]" || c == "}" || c == ":") begin
              leaf_done(TYPE_PRIMITIVE, pend_start, p);
              lex_mode = M_BETWEEN;
              if (err_q == ERR_NONE) between_tokens(c, p);
            end else if (c < CTRL_LIMIT || c == CH_QUOTE || c == "{" || c == "[") begin
              err_q = ERR_MALFORMED;
            end
          end
          M_STRING: begin
            if (c == CH_QUOTE) begin
              leaf_done(TYPE_STRING, pend_start, p);
              lex_mode = M_BETWEEN;
            end else if (c < CTRL_LIMIT) err_q = ERR_MALFORMED;
            else if (c == CH_BSLASH) lex_mode = M_ESCAPE;
          end
          M_ESCAPE: begin
            if (c == CH_U) begin
              lex_mode = M_HEX;
              hex_cnt  = 4;
            end else if (c == CH_QUOTE || c == CH_BSLASH || c == "/" || c == "b" ||
                         c == "f" || c == "n" || c == "r" || c == "t") begin
              lex_mode = M_STRING;
            end else err_q = ERR_MALFORMED;
          end
          M_HEX: begin
            if (!((c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                  (c >= "A" && c <= "F"))) begin
              err_q = ERR_MALFORMED;
            end else begin
              if (hex_cnt > 0) hex_cnt--;
              if (hex_cnt == 0) lex_mode = M_STRING;
            end
          end
          default: between_tokens(c, p);
        endcase
      end
    end
    if (fin) begin
      if (err_q == ERR_NONE) begin
        if (lex_mode == M_PRIM) leaf_done(TYPE_PRIMITIVE, pend_start, pos_q);
        else if (lex_mode != M_BETWEEN) err_q = ERR_MALFORMED;
      end
      if (err_q == ERR_NONE && (cur_open >= 0 || top_vals != 1)) err_q = ERR_MALFORMED;
      want_q.push_back(mk(KIND_STATUS, 0, 2'd0, '0, '0, 0, 0, err_q, alloc_ptr));
      clear_text();
    end
    if (want_q.size() > n_prev) want_q[want_q.size()-1].run_last = 1'b1;
  endfunction

  function automatic int field_ok(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d got %0d", $time, nm, e, a);
      return 0;
    end
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rec_t got, exp_w;
    int ok;
    if (!rst_ni) begin
      limit_q      = LIMIT_RESET;
      want_q.delete();
      clear_text();
      fail_count_o = 0;
      checked_o    = 0;
      statuses_o   = 0;
    end else begin
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.record_kind, out_i.token_index, out_i.token_type, out_i.token_start,
                out_i.token_end, out_i.child_count, out_i.parent_index,
                out_i.parse_status, out_i.token_total, out_i.run_last};
        if (want_q.size() == 0) begin
          $display("%0t unexpected word: got %p", $time, got);
          fail_count_o++;
        end else begin
          exp_w = want_q.pop_front();
          ok = field_ok("record_kind", exp_w.record_kind, got.record_kind)
             & field_ok("token_index", exp_w.token_index, got.token_index)
             & field_ok("token_type", exp_w.token_type, got.token_type)
             & field_ok("token_start", exp_w.token_start, got.token_start)
             & field_ok("token_end", exp_w.token_end, got.token_end)
             & field_ok("child_count", exp_w.child_count, got.child_count)
             & field_ok("parent_index", exp_w.parent_index, got.parent_index)
             & field_ok("parse_status", exp_w.parse_status, got.parse_status)
             & field_ok("token_total", exp_w.token_total, got.token_total)
             & field_ok("run_last", exp_w.run_last, got.run_last);
          if (!ok) fail_count_o++;
          checked_o++;
          if (exp_w.record_kind == KIND_STATUS) statuses_o++;
        end
      end
      if (in_i.valid && in_i.ready) lex_byte(in_i.data_byte, in_i.last_byte);
    end
    pending_o = want_q.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the json stream tokenizer: directed texts, then
// random well-formed json with some corrupted texts and noise, across several
// token limits and idling patterns
// ----------------------------------------------------------------------------

module tb;
  import jst_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  int                 fails, pending, checked, statuses;
  int                 cycles;
  int                 idle_pct, stall_pct;
  int                 bytes_sent, texts_sent;
  logic [7:0]         txt[$];

  jst_byte_if in_if ();
  jst_rec_if  out_if ();

  json_stream_tokenizer_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  jst_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .statuses_o   (statuses)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("status: fail");
      $finish;
    end
  end

  // receiver, stalls at the phase rate
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---- text builders, append to txt ----
  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic void put_ws();
    int r;
    r = $urandom_range(7);
    if (r == 0) txt.push_back(8'h20);
    else if (r == 1) txt.push_back(8'h09);
    else if (r == 2) txt.push_back(8'h0d);
    else if (r == 3) txt.push_back(8'h0a);
  endfunction

  function automatic void put_hex();
    int r;
    r = $urandom_range(21);
    if (r < 10) txt.push_back(8'(8'h30 + r));
    else if (r < 16) txt.push_back(8'(8'h61 + r - 10));
    else txt.push_back(8'(8'h41 + r - 16));
  endfunction

  // string with printable, high, escaped and \u content
  function automatic void put_json_str();
    int len;
    int r;
    logic [7:0] c;
    txt.push_back(CH_QUOTE);
    len = $urandom_range(5);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(9);
      if (r < 5) begin
        c = 8'($urandom_range(8'h20, 8'h7e));
        if (c == CH_QUOTE || c == CH_BSLASH) c = "x";
        txt.push_back(c);
      end else if (r < 7) begin
        txt.push_back(8'($urandom_range(8'h80, 8'hff)));
      end else if (r < 9) begin
        txt.push_back(CH_BSLASH);
        case ($urandom_range(7))
          0: txt.push_back(CH_QUOTE);
          1: txt.push_back(CH_BSLASH);
          2: txt.push_back("/");
          3: txt.push_back("b");
          4: txt.push_back("f");
          5: txt.push_back("n");
          6: txt.push_back("r");
          default: txt.push_back("t");
        endcase
      end else begin
        txt.push_back(CH_BSLASH);
        txt.push_back(CH_U);
        repeat (4) put_hex();
      end
    end
    txt.push_back(CH_QUOTE);
  endfunction

  function automatic void put_value(int depth);
    int r;
    int n;
    r = $urandom_range(9);
    put_ws();
    if (depth < 3 && r < 2) begin
      txt.push_back("{");
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) txt.push_back(",");
        put_ws();
        put_json_str();
        put_ws();
        txt.push_back(":");
        put_value(depth + 1);
      end
      put_ws();
      txt.push_back("}");
    end else if (depth < 3 && r < 4) begin
      txt.push_back("[");
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) txt.push_back(",");
        put_value(depth + 1);
      end
      put_ws();
      txt.push_back("]");
    end else if (r < 7) begin
      put_json_str();
    end else begin
      case ($urandom_range(4))
        0: put_str("true");
        1: put_str("false");
        2: put_str("null");
        3: put_str("-12.5e+3");
        default: put_str($sformatf("%0d", $urandom_range(99999)));
      endcase
    end
    put_ws();
  endfunction

  // one random text: mostly well formed, some corrupted, some plain noise
  function automatic void make_text();
    int r;
    txt.delete();
    r = $urandom_range(99);
    if (r < 6) begin
      repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(255)));
    end else begin
      put_value(0);
      if (r < 10) put_value(0);                 // two top-level values
      if (r >= 10 && r < 24)
        txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
      else if (r >= 24 && r < 30 && txt.size() > 1)
        txt.pop_back();                         // truncated text
    end
  endfunction

  // ---- channel and register drivers ----
  task automatic send_text();
    for (int i = 0; i < txt.size(); i++) begin
      if ($urandom_range(99) < idle_pct) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      in_if.valid     <= 1'b1;
      in_if.data_byte <= txt[i];
      in_if.last_byte <= (i == txt.size() - 1);
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      bytes_sent++;
    end
    texts_sent++;
  endtask

  task automatic send_str(string s);
    txt.delete();
    put_str(s);
    send_text();
  endtask

  // drain, let a pending close finish, then write the limit
  task automatic set_limit(int value);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value[LIMIT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  int limits[6] = '{256, 1, 3, 0, 511, 40};

  initial begin
    int phase_bytes;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    out_if.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: nesting, a simple escape, \u with mixed case, primitive closed by a bracket
    send_str("[{\"\\u0aF9\\n\":t}]");
    send_str("]");                             // close with nothing open
    send_str("[}");                            // close of the wrong kind
    txt.delete();
    txt.push_back(CH_QUOTE); txt.push_back(8'h01); txt.push_back(CH_QUOTE);
    send_text();                               // control byte in a string
    send_str("\"\\q\"");                       // bad escape
    send_str("1 2");                           // two top-level values
    send_str("[");                             // container left open
    send_str("7");                             // primitive ended by the final byte

    // long flat array of primitives
    txt.delete();
    txt.push_back("[");
    for (int i = 0; i < 30; i++) begin
      if (i > 0) txt.push_back(",");
      txt.push_back("0");
    end
    txt.push_back("]");
    send_text();

    for (int ph = 0; ph < 6; ph++) begin
      set_limit(limits[ph]);
      phase_bytes = 0;
      while (phase_bytes < 40) begin
        case ((bytes_sent / 16) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 81; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 81; end
          default: begin idle_pct = 23; stall_pct = 23; end
        endcase
        make_text();
        phase_bytes += txt.size();
        send_text();
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d bytes in %0d texts over six token limits", bytes_sent, texts_sent);
    $display("checked %0d words, %0d of them final status", checked, statuses);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
